// ----- hdl/circular_deque_value_removal_defines.svh -----
`ifndef CIRCULAR_DEQUE_VALUE_REMOVAL_DEFINES_SVH
`define CIRCULAR_DEQUE_VALUE_REMOVAL_DEFINES_SVH

// Same-cycle implication check, sampled on clk, off while rst_n is low
`define CDVR_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdvr: same-cycle check failed");

// Next-cycle implication check, sampled on clk, off while rst_n is low
`define CDVR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdvr: next-cycle check failed");

`endif

// ----- hdl/cdvr_pkg.sv -----
package cdvr_pkg;

    // Storage sizing
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Fixed field widths of the channels
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REM_VALUE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] removed_value;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_REPLY
    } state_t;

    // Read address source, as an offset from the front
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_LAST,
        RD_IDX1,
        RD_IDX2
    } rd_sel_t;

    // Write address and data source
    typedef enum logic [1:0] {
        WR_FRONT_PREV,
        WR_BACK,
        WR_SHIFT
    } wr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic                ld_cmd;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        wr_sel_t             wr_sel;
        logic                front_dec;
        logic                front_inc;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                idx_clr;
        logic                idx_inc;
        logic                res_ld;
        logic [STATUS_W-1:0] res_status;
        logic                res_take;
        logic                rsp_ld;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              match;
        logic              idx_last;
        logic              idx_next_last;
        logic              rsp_free;
    } dp_stat_t;

    // Ring position of base + off, off never above CAPACITY
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ----- hdl/cdvr_ram.sv -----
module cdvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/cdvr_ctrl.sv -----
module cdvr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cdvr_pkg::dp_stat_t stat,
    output cdvr_pkg::dp_cmd_t  ctl
);

    cdvr_pkg::state_t state_reg;
    cdvr_pkg::state_t state_next;

    logic is_insert;
    logic is_pop;
    logic is_remval;

    assign is_insert = (stat.func == cdvr_pkg::FN_INS_FRONT) ||
                       (stat.func == cdvr_pkg::FN_INS_BACK);
    assign is_pop    = (stat.func == cdvr_pkg::FN_REM_FRONT) ||
                       (stat.func == cdvr_pkg::FN_REM_BACK);
    assign is_remval = (stat.func == cdvr_pkg::FN_REM_VALUE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdvr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdvr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cdvr_pkg::S_DECODE;
                end
            end
            cdvr_pkg::S_DECODE:
            begin
                if (is_pop && !stat.empty)
                begin
                    state_next = cdvr_pkg::S_POP;
                end
                else if (is_remval && !stat.empty)
                begin
                    state_next = cdvr_pkg::S_SCAN;
                end
                else
                begin
                    state_next = cdvr_pkg::S_REPLY;
                end
            end
            cdvr_pkg::S_POP:
            begin
                state_next = cdvr_pkg::S_REPLY;
            end
            cdvr_pkg::S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = stat.idx_last ? cdvr_pkg::S_REPLY : cdvr_pkg::S_SHIFT;
                end
                else if (stat.idx_last)
                begin
                    state_next = cdvr_pkg::S_REPLY;
                end
            end
            cdvr_pkg::S_SHIFT:
            begin
                if (stat.idx_next_last)
                begin
                    state_next = cdvr_pkg::S_REPLY;
                end
            end
            cdvr_pkg::S_REPLY:
            begin
                if (stat.rsp_free)
                begin
                    state_next = cdvr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdvr_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl            = '0;
        ctl.rd_sel     = cdvr_pkg::RD_FRONT;
        ctl.wr_sel     = cdvr_pkg::WR_BACK;
        ctl.res_status = cdvr_pkg::ST_DONE;
        cmd_ready      = 1'b0;
        case (state_reg)
            cdvr_pkg::S_IDLE:
            begin
                cmd_ready  = 1'b1;
                ctl.ld_cmd = cmd_valid;
            end
            cdvr_pkg::S_DECODE:
            begin
                if (is_insert)
                begin
                    ctl.res_ld = 1'b1;
                    if (stat.full)
                    begin
                        ctl.res_status = cdvr_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.cnt_inc = 1'b1;
                        if (stat.func == cdvr_pkg::FN_INS_FRONT)
                        begin
                            ctl.wr_sel    = cdvr_pkg::WR_FRONT_PREV;
                            ctl.front_dec = 1'b1;
                        end
                    end
                end
                else if (is_pop || is_remval)
                begin
                    if (stat.empty)
                    begin
                        ctl.res_ld     = 1'b1;
                        ctl.res_status = cdvr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.rd_en   = 1'b1;
                        ctl.idx_clr = is_remval;
                        if (stat.func == cdvr_pkg::FN_REM_BACK)
                        begin
                            ctl.rd_sel = cdvr_pkg::RD_LAST;
                        end
                    end
                end
                else
                begin
                    // unused codes: no change
                    ctl.res_ld = 1'b1;
                end
            end
            cdvr_pkg::S_POP:
            begin
                ctl.res_ld    = 1'b1;
                ctl.res_take  = 1'b1;
                ctl.cnt_dec   = 1'b1;
                ctl.front_inc = (stat.func == cdvr_pkg::FN_REM_FRONT);
            end
            cdvr_pkg::S_SCAN:
            begin
                if (stat.match)
                begin
                    ctl.res_ld   = 1'b1;
                    ctl.res_take = 1'b1;
                    if (stat.idx_last)
                    begin
                        ctl.cnt_dec = 1'b1;
                    end
                    else
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = cdvr_pkg::RD_IDX1;
                    end
                end
                else if (stat.idx_last)
                begin
                    ctl.res_ld     = 1'b1;
                    ctl.res_status = cdvr_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_sel  = cdvr_pkg::RD_IDX1;
                    ctl.idx_inc = 1'b1;
                end
            end
            cdvr_pkg::S_SHIFT:
            begin
                // move the entry behind the gap one place forward
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = cdvr_pkg::WR_SHIFT;
                ctl.idx_inc = 1'b1;
                if (stat.idx_next_last)
                begin
                    ctl.cnt_dec = 1'b1;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = cdvr_pkg::RD_IDX2;
                end
            end
            cdvr_pkg::S_REPLY:
            begin
                ctl.rsp_ld = stat.rsp_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// ----- hdl/cdvr_dpath.sv -----
module cdvr_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  cdvr_pkg::cmd_item_t cmd,
    input  cdvr_pkg::dp_cmd_t   ctl,
    output cdvr_pkg::dp_stat_t  stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cdvr_pkg::rsp_item_t rsp
);

    logic [cdvr_pkg::ADDR_W-1:0]     front_reg;
    logic [cdvr_pkg::ADDR_W-1:0]     front_next;
    logic [cdvr_pkg::CNT_W-1:0]      cnt_reg;
    logic [cdvr_pkg::CNT_W-1:0]      cnt_next;
    logic [cdvr_pkg::CNT_W-1:0]      idx_reg;
    logic [cdvr_pkg::FUNC_W-1:0]     func_reg;
    logic [cdvr_pkg::DATA_WIDTH-1:0] word_reg;
    logic [cdvr_pkg::STATUS_W-1:0]   res_status_reg;
    logic [cdvr_pkg::DATA_WIDTH-1:0] removed_reg;
    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    cdvr_pkg::rsp_item_t             rsp_reg;

    logic [63:0]                     value_wide;
    logic [63:0]                     removed_wide;
    logic [63:0]                     cnt_wide;
    logic [cdvr_pkg::ADDR_W-1:0]     front_prev;
    logic [cdvr_pkg::ADDR_W-1:0]     front_succ;
    logic [cdvr_pkg::CNT_W-1:0]      rd_off;
    logic [cdvr_pkg::ADDR_W-1:0]     rd_addr;
    logic [cdvr_pkg::ADDR_W-1:0]     wr_addr;
    logic [cdvr_pkg::DATA_WIDTH-1:0] wr_data;
    logic [cdvr_pkg::DATA_WIDTH-1:0] rd_data;

    // Only the low DATA_WIDTH bits of the input word are kept
    assign value_wide = {32'b0, cmd.value};

    // Ring neighbors of the front
    assign front_prev = (front_reg == '0) ? cdvr_pkg::ADDR_W'(cdvr_pkg::CAPACITY - 1)
                                          : front_reg - cdvr_pkg::ADDR_W'(1);
    assign front_succ = (front_reg == cdvr_pkg::ADDR_W'(cdvr_pkg::CAPACITY - 1))
                        ? '0 : front_reg + cdvr_pkg::ADDR_W'(1);

    // Read address
    always_comb
    begin
        case (ctl.rd_sel)
            cdvr_pkg::RD_FRONT: rd_off = '0;
            cdvr_pkg::RD_LAST:  rd_off = cnt_reg - cdvr_pkg::CNT_W'(1);
            cdvr_pkg::RD_IDX1:  rd_off = idx_reg + cdvr_pkg::CNT_W'(1);
            cdvr_pkg::RD_IDX2:  rd_off = idx_reg + cdvr_pkg::CNT_W'(2);
            default:            rd_off = '0;
        endcase
    end
    assign rd_addr = cdvr_pkg::ring_add(front_reg, rd_off);

    // Write address and data
    always_comb
    begin
        case (ctl.wr_sel)
            cdvr_pkg::WR_FRONT_PREV:
            begin
                wr_addr = front_prev;
                wr_data = word_reg;
            end
            cdvr_pkg::WR_BACK:
            begin
                wr_addr = cdvr_pkg::ring_add(front_reg, cnt_reg);
                wr_data = word_reg;
            end
            cdvr_pkg::WR_SHIFT:
            begin
                wr_addr = cdvr_pkg::ring_add(front_reg, idx_reg);
                wr_data = rd_data;
            end
            default:
            begin
                wr_addr = front_prev;
                wr_data = word_reg;
            end
        endcase
    end

    cdvr_ram #(
        .WIDTH (cdvr_pkg::DATA_WIDTH),
        .DEPTH (cdvr_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Front and count
    always_comb
    begin
        front_next = front_reg;
        if (ctl.front_dec)
        begin
            front_next = front_prev;
        end
        else if (ctl.front_inc)
        begin
            front_next = front_succ;
        end
        cnt_next = cnt_reg;
        if (ctl.cnt_inc)
        begin
            cnt_next = cnt_reg + cdvr_pkg::CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            cnt_next = cnt_reg - cdvr_pkg::CNT_W'(1);
        end
    end

    // Output register: cleared on transfer, reloaded by the controller
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.rsp_ld)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Command latch, scan index, pending result
    always_ff @(posedge clk)
    begin
        if (ctl.ld_cmd)
        begin
            func_reg <= cmd.func;
            word_reg <= value_wide[cdvr_pkg::DATA_WIDTH-1:0];
        end
        if (ctl.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_reg <= idx_reg + cdvr_pkg::CNT_W'(1);
        end
        if (ctl.res_ld)
        begin
            res_status_reg <= ctl.res_status;
            removed_reg    <= ctl.res_take ? rd_data : '0;
        end
        if (ctl.rsp_ld)
        begin
            rsp_reg.status        <= res_status_reg;
            rsp_reg.count         <= cnt_wide[cdvr_pkg::COUNT_W-1:0];
            rsp_reg.removed_value <= signed'(removed_wide[cdvr_pkg::VALUE_W-1:0]);
        end
    end

    assign removed_wide = 64'(removed_reg);
    assign cnt_wide     = 64'(cnt_reg);

    // Status to controller
    assign stat.func          = func_reg;
    assign stat.full          = (cnt_reg == cdvr_pkg::CNT_W'(cdvr_pkg::CAPACITY));
    assign stat.empty         = (cnt_reg == '0);
    assign stat.match         = (rd_data == word_reg);
    assign stat.idx_last      = (idx_reg == cnt_reg - cdvr_pkg::CNT_W'(1));
    assign stat.idx_next_last = (idx_reg + cdvr_pkg::CNT_W'(2) == cnt_reg);
    assign stat.rsp_free      = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/circular_deque_value_removal.sv -----
// After command transfer, inserts, refusals and unused codes pass DECODE and REPLY;
// front/back removals pass DECODE, POP, REPLY; remove by value passes DECODE, SCAN,
// SHIFT if needed, REPLY (one compare or move per entry through the RAM read port).
// Throughput: one command at a time; the next is taken once the result is in
// the output register, even while that result still waits to be taken.
// Reset (rst_n, async, active low) empties the store; RAM contents are not cleared.
module circular_deque_value_removal (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cdvr_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cdvr_pkg::rsp_item_t rsp
);

`include "circular_deque_value_removal_defines.svh"

    cdvr_pkg::dp_cmd_t  dp_cmd;
    cdvr_pkg::dp_stat_t dp_stat;

    cdvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (dp_stat),
        .ctl       (dp_cmd)
    );

    cdvr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (dp_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Checks
    `CDVR_ASSERT_NOW(a_rsp_ld_free, dp_cmd.rsp_ld, dp_stat.rsp_free)
    `CDVR_ASSERT_NOW(a_cnt_one_way, dp_cmd.cnt_inc, !dp_cmd.cnt_dec)
    `CDVR_ASSERT_NOW(a_no_insert_full, dp_cmd.cnt_inc, !dp_stat.full)
    `CDVR_ASSERT_NEXT(a_busy_after_xfer, cmd_valid && cmd_ready, !cmd_ready)

endmodule
